### sv/mbsp_pkg.sv
// shared types, byte codes and decode functions of the midi byte stream parser
package mbsp_pkg;

  localparam int SysexSizeDef = 64;
  localparam int ByteW        = 8;
  localparam int ChanW        = 5;
  localparam int LenW         = 7;
  localparam int InDataW      = 8;
  localparam int OutFieldW    = ChanW + 3 * ByteW + LenW;
  localparam int OutDataW     = ((OutFieldW + 7) / 8) * 8;
  localparam int OutPadW      = OutDataW - OutFieldW;

  localparam logic [7:0] StNone    = 8'h00;
  localparam logic [7:0] StNoteOff = 8'h80;
  localparam logic [7:0] StNoteOn  = 8'h90;
  localparam logic [7:0] StPolyAt  = 8'hA0;
  localparam logic [7:0] StCtrl    = 8'hB0;
  localparam logic [7:0] StProg    = 8'hC0;
  localparam logic [7:0] StChanAt  = 8'hD0;
  localparam logic [7:0] StBend    = 8'hE0;
  localparam logic [7:0] StSysex   = 8'hF0;
  localparam logic [7:0] StMtc     = 8'hF1;
  localparam logic [7:0] StSongPos = 8'hF2;
  localparam logic [7:0] StSongSel = 8'hF3;
  localparam logic [7:0] StUndefA  = 8'hF4;
  localparam logic [7:0] StUndefB  = 8'hF5;
  localparam logic [7:0] StTune    = 8'hF6;
  localparam logic [7:0] StEox     = 8'hF7;
  localparam logic [7:0] StClock   = 8'hF8;
  localparam logic [7:0] StUndefC  = 8'hF9;
  localparam logic [7:0] StStart   = 8'hFA;
  localparam logic [7:0] StCont    = 8'hFB;
  localparam logic [7:0] StStop    = 8'hFC;
  localparam logic [7:0] StUndefD  = 8'hFD;
  localparam logic [7:0] StSense   = 8'hFE;
  localparam logic [7:0] StReset   = 8'hFF;
  localparam logic [3:0] NibbleNone = 4'h0;

  localparam logic [ChanW-1:0] ChanNone = '0;
  localparam logic [LenW-1:0]  LenOne   = LenW'(1);
  localparam logic [LenW-1:0]  LenTwo   = LenW'(2);
  localparam logic [LenW-1:0]  LenThree = LenW'(3);

  typedef struct packed {
    logic [7:0]       msg_type;
    logic [ChanW-1:0] channel;
    logic [7:0]       data_first;
    logic [7:0]       data_second;
    logic [LenW-1:0]  msg_length;
    logic [7:0]       sysex_byte;
    logic             last;
  } res_t;

  // parser context besides the pending index
  typedef struct packed {
    logic [7:0] run_st;
    logic [7:0] st;
    logic [7:0] d1;
    logic       three;
  } ctx_t;

  typedef struct packed {
    logic emit;
    logic run;
    logic wr;
  } act_t;

  function automatic logic [7:0] status_type(logic [7:0] s);
    if (!s[7] || s == StUndefA || s == StUndefB || s == StUndefC || s == StUndefD) begin
      return StNone;
    end
    if (s < StSysex) begin
      return {s[7:4], NibbleNone};
    end
    return s;
  endfunction

  function automatic logic is_realtime(logic [7:0] b);
    return b == StClock || b == StStart || b == StCont || b == StStop ||
           b == StSense || b == StReset;
  endfunction

  function automatic logic is_chan_status(logic [7:0] s);
    return s[7] && (s < StSysex);
  endfunction

endpackage

### sv/midi_byte_stream_parser_core.sv
// top level of the midi byte stream parser with running status and sysex buffer
//
//   channel   | direction | tdata                          | tuser    | tlast
//   s_axis    | in        | rx_byte                        | -        | -
//   m_axis    | out       | channel, data_first,           | msg_type | last
//             |           | data_second, msg_length,       |          |
//             |           | sysex_byte                     |          |
//
// a byte waits in the input register, then passes the step logic into the output register
// a completed sysex of n bytes is then replayed from the buffer ram, with one buffer
// ram read and one output load per byte
// reset clears the parser context at once, the buffer ram needs no clearing
// the input register takes the next byte while a result waits in the output register
module midi_byte_stream_parser_core #(
  parameter int SYSEX_SIZE = mbsp_pkg::SysexSizeDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mbsp_pkg::InDataW-1:0]  s_axis_tdata,   // rx_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // channel, data_first, data_second, msg_length, sysex_byte, zero pad
  output logic [mbsp_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [7:0]                    m_axis_tuser,   // msg_type
  output logic                          m_axis_tlast
);
  import mbsp_pkg::*;

  localparam int AW = $clog2(SYSEX_SIZE);

  localparam logic [1:0] S_IN  = 2'd0;
  localparam logic [1:0] S_RD  = 2'd1;
  localparam logic [1:0] S_OUT = 2'd2;

  logic [1:0]    state_q, state_d;
  logic          in_valid_q, in_valid_d;
  logic [7:0]    in_byte_q;
  ctx_t          ctx_q, ctx_d, step_ctx;
  logic [AW-1:0] idx_q, idx_d, step_idx;
  act_t          step_act;
  res_t          step_res;
  res_t          out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic [AW-1:0] run_k_q, run_k_d;
  logic [AW-1:0] run_last_q, run_last_d;
  logic          out_free;
  logic          step_go;
  logic          ram_we;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_go       = (state_q == S_IN) && in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q;
  assign ram_we        = step_go && step_act.wr;
  assign ram_re        = (state_q == S_RD);

  mbsp_step #(
    .SYSEX_SIZE(SYSEX_SIZE)
  ) u_step (
    .rx_byte_i(in_byte_q),
    .ctx_i    (ctx_q),
    .idx_i    (idx_q),
    .ctx_o    (step_ctx),
    .idx_o    (step_idx),
    .act_o    (step_act),
    .res_o    (step_res)
  );

  mbsp_ram #(
    .W    (ByteW),
    .DEPTH(SYSEX_SIZE)
  ) u_sysex_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(in_byte_q),
    .re_i   (ram_re),
    .raddr_i(run_k_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    in_valid_d  = in_valid_q;
    ctx_d       = ctx_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    run_k_d     = run_k_q;
    run_last_d  = run_last_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end
    unique case (state_q)
      S_IN: begin
        if (step_go) begin
          in_valid_d = 1'b0;
          ctx_d      = step_ctx;
          idx_d      = step_idx;
          if (step_act.emit) begin
            out_d       = step_res;
            out_valid_d = 1'b1;
          end
          if (step_act.run) begin
            run_k_d    = '0;
            run_last_d = idx_q;
            state_d    = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_d             = '0;
          out_d.msg_type    = StSysex;
          out_d.msg_length  = LenW'(run_last_q) + LenW'(1);
          out_d.sysex_byte  = ram_rdata;
          out_d.last        = (run_k_q == run_last_q);
          out_valid_d       = 1'b1;
          if (run_k_q == run_last_q) begin
            state_d = S_IN;
          end else begin
            run_k_d = run_k_q + AW'(1);
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IN;
      in_valid_q  <= 1'b0;
      ctx_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_valid_q  <= in_valid_d;
      ctx_q       <= ctx_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    out_q      <= out_d;
    run_k_q    <= run_k_d;
    run_last_q <= run_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.msg_type;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, out_q.sysex_byte, out_q.msg_length,
                          out_q.data_second, out_q.data_first, out_q.channel};

endmodule

### sv/mbsp_ram.sv
// generic simple dual port ram with registered read
module mbsp_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/mbsp_step.sv
// one parser step: next context, buffer write and result for one received byte
module mbsp_step #(
  parameter int SYSEX_SIZE = 64
) (
  input  logic [7:0]                    rx_byte_i,
  input  mbsp_pkg::ctx_t                ctx_i,
  input  logic [$clog2(SYSEX_SIZE)-1:0] idx_i,
  output mbsp_pkg::ctx_t                ctx_o,
  output logic [$clog2(SYSEX_SIZE)-1:0] idx_o,
  output mbsp_pkg::act_t                act_o,
  output mbsp_pkg::res_t                res_o
);
  import mbsp_pkg::*;

  localparam int AW = $clog2(SYSEX_SIZE);

  logic [7:0] b;
  logic [7:0] t_new;
  logic [7:0] t_rs;
  logic [7:0] t_st;
  logic       rs_ok;
  logic       st_chan;
  logic       done;

  assign b       = rx_byte_i;
  assign t_new   = status_type(b);
  assign t_rs    = status_type(ctx_i.run_st);
  assign t_st    = status_type(ctx_i.st);
  assign rs_ok   = is_chan_status(ctx_i.run_st);
  assign st_chan = is_chan_status(ctx_i.st);
  assign done    = ctx_i.three ? (idx_i == AW'(2)) : (idx_i == AW'(1));

  always_comb begin
    ctx_o = ctx_i;
    idx_o = idx_i;
    act_o = '0;
    res_o = '0;
    res_o.last = 1'b1;
    if (idx_i == '0) begin
      if (rs_ok && !b[7]) begin
        ctx_o.st = ctx_i.run_st;
        ctx_o.d1 = b;
        if (t_rs == StProg || t_rs == StChanAt) begin
          act_o.emit        = 1'b1;
          res_o.msg_type    = t_rs;
          res_o.channel     = ChanW'(ctx_i.run_st[3:0]) + ChanW'(1);
          res_o.data_first  = b;
          res_o.msg_length  = LenTwo;
        end else begin
          ctx_o.three = 1'b1;
          idx_o       = AW'(2);
        end
      end else begin
        unique case (t_new) inside
          StTune, StClock, StStart, StCont, StStop, StSense, StReset: begin
            act_o.emit       = 1'b1;
            res_o.msg_type   = t_new;
            res_o.msg_length = LenOne;
          end
          StProg, StChanAt, StMtc, StSongSel: begin
            ctx_o.st    = b;
            ctx_o.three = 1'b0;
            idx_o       = AW'(1);
          end
          StNoteOff, StNoteOn, StPolyAt, StCtrl, StBend, StSongPos: begin
            ctx_o.st    = b;
            ctx_o.three = 1'b1;
            idx_o       = AW'(1);
          end
          StSysex: begin
            ctx_o.st     = b;
            ctx_o.run_st = StNone;
            act_o.wr     = 1'b1;
            idx_o        = AW'(1);
          end
          default: begin
            ctx_o.run_st = StNone;
          end
        endcase
      end
    end else if (is_realtime(b)) begin
      act_o.emit       = 1'b1;
      res_o.msg_type   = b;
      res_o.msg_length = LenOne;
    end else if (b == StEox) begin
      ctx_o.run_st = StNone;
      idx_o        = '0;
      if (ctx_i.st == StSysex) begin
        act_o.wr  = 1'b1;
        act_o.run = 1'b1;
      end
    end else if (ctx_i.st == StSysex) begin
      if (idx_i == AW'(SYSEX_SIZE - 1)) begin
        ctx_o.run_st = StNone;
        idx_o        = '0;
      end else begin
        act_o.wr = 1'b1;
        idx_o    = idx_i + AW'(1);
      end
    end else if (done) begin
      act_o.emit       = 1'b1;
      res_o.msg_type   = t_st;
      res_o.channel    = st_chan ? (ChanW'(ctx_i.st[3:0]) + ChanW'(1)) : ChanNone;
      res_o.data_first = ctx_i.three ? ctx_i.d1 : b;
      res_o.data_second = ctx_i.three ? b : 8'h00;
      res_o.msg_length = ctx_i.three ? LenThree : LenTwo;
      ctx_o.run_st     = st_chan ? ctx_i.st : StNone;
      idx_o            = '0;
    end else begin
      ctx_o.d1 = b;
      idx_o    = idx_i + AW'(1);
    end
  end

endmodule

### sv/mbsp_checker.sv
// port level checker of the midi byte stream parser and its bind
module mbsp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [mbsp_pkg::InDataW-1:0]  s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mbsp_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [7:0]                    m_axis_tuser,
  input logic                          m_axis_tlast
);
  import mbsp_pkg::*;

  logic [ChanW-1:0] chan;
  logic [LenW-1:0]  len;
  logic [7:0]       sx;

  assign chan = m_axis_tdata[ChanW-1:0];
  assign len  = m_axis_tdata[ChanW+2*ByteW+LenW-1:ChanW+2*ByteW];
  assign sx   = m_axis_tdata[OutFieldW-1:ChanW+2*ByteW+LenW];

  // stalled input request holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("input request changed while stalled");

  // stalled request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output request changed while stalled");

  // channel only on channel messages
  a_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser < StSysex) == (chan != ChanNone)) &&
      (chan <= ChanW'(16)))
    else $error("channel does not match message type");

  // non sysex results are single, short and carry no sysex byte
  a_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != StSysex) |->
      m_axis_tlast && (sx == 8'h00) && (len >= LenOne) && (len <= LenThree))
    else $error("malformed non sysex result");

  // a sysex run opens with its start byte
  a_sysex_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast ##1
      m_axis_tvalid && (m_axis_tuser == StSysex) |-> sx == StSysex)
    else $error("sysex run does not start with its start byte");

endmodule

bind midi_byte_stream_parser_core mbsp_checker u_mbsp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
